@@ src/esc_dec_pkg.sv @@
// Shared types and character constants for the escape sequence decoder.
`default_nettype none

package esc_dec_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_OCT    = 2'd2,
        MODE_HEX    = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  value;
        logic [1:0]  count;
    } dec_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        end_of_text;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]  n_results;
        result_t     res0;
        result_t     res1;
        dec_state_t  state;
    } dec_out_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LB        = 8'h62;
    localparam logic [7:0] CH_LF_LETTER = 8'h66;
    localparam logic [7:0] CH_LN        = 8'h6E;
    localparam logic [7:0] CH_LR        = 8'h72;
    localparam logic [7:0] CH_LT        = 8'h74;
    localparam logic [7:0] CH_LV        = 8'h76;
    localparam logic [7:0] CH_LX        = 8'h78;

    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

endpackage

`default_nettype wire

@@ src/escape_sequence_decoder.sv @@
// Top level of the C string escape decoder: state registers and result buffer.
`default_nettype none

// Decodes C backslash escapes from a byte stream, one byte per transfer. A byte
// is taken every cycle while results drain; each accepted byte gives zero, one or
// two results, the first appearing on the m_ side the cycle after acceptance.
// A byte that gives two results (a flushed numeric value followed by the byte
// itself, or a trailing backslash followed by the terminator) stalls input
// until the second result leaves the two-entry result buffer (one per cycle).
// A zero byte ends the text, emits a terminator marked on m_tuser and resets.
module escape_sequence_decoder (
    input  wire  logic       aclk,
    input  wire  logic       aresetn,
    input  wire  logic       s_tvalid,
    output       logic       s_tready,
    input  wire  logic [7:0] s_tdata,   // [7:0] in_byte
    output       logic       m_tvalid,
    input  wire  logic       m_tready,
    output       logic [7:0] m_tdata,   // [7:0] out_byte
    output       logic       m_tuser,   // [0] end_of_text
    output       logic       m_tlast    // last_of_run
);

    esc_dec_pkg::dec_state_t state_reg;
    esc_dec_pkg::dec_state_t state_next;
    esc_dec_pkg::dec_out_t   dec;
    esc_dec_pkg::result_t    slot0_reg;
    esc_dec_pkg::result_t    slot0_next;
    esc_dec_pkg::result_t    slot1_reg;
    esc_dec_pkg::result_t    slot1_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic                    s_xfer;
    logic                    m_xfer;

    esc_dec_core u_core (
        .in_byte (s_tdata),
        .state   (state_reg),
        .dec     (dec)
    );

    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot0_reg.out_byte;
    assign m_tuser  = slot0_reg.end_of_text;
    assign m_tlast  = slot0_reg.last_of_run;

    always_comb begin
        state_next = state_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (m_xfer) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (s_xfer) begin
            state_next = dec.state;
            slot0_next = dec.res0;
            slot1_next = dec.res1;
            count_next = dec.n_results;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            count_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer overfilled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (dec.n_results != 2'd0)) |=> m_tvalid)
        else $error("accepted byte produced no result");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !slot0_reg.last_of_run)
        else $error("first of two results marked last");

    a_normal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == esc_dec_pkg::MODE_NORMAL) |->
            ((state_reg.value == 8'd0) && (state_reg.count == 2'd0)))
        else $error("stale escape value in normal mode");

    a_eot_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (dec.n_results != 2'd0) &&
         (((dec.n_results == 2'd1) && dec.res0.end_of_text) || dec.res1.end_of_text))
        |=> (state_reg.mode == esc_dec_pkg::MODE_NORMAL))
        else $error("terminator did not reset decoder");

endmodule

`default_nettype wire

@@ src/esc_dec_core.sv @@
// Combinational decode of one text byte against the current escape state.
`default_nettype none

module esc_dec_core (
    input  wire  logic [7:0]                in_byte,
    input  wire  esc_dec_pkg::dec_state_t   state,
    output       esc_dec_pkg::dec_out_t     dec
);

    logic       is_oct;
    logic       is_dec;
    logic       is_uhex;
    logic       is_lhex;
    logic [3:0] hex_val;
    logic [7:0] oct_acc;
    logic [7:0] hex_acc;
    logic [1:0] cnt_inc;
    logic [7:0] esc_char;

    always_comb begin
        is_oct  = (in_byte >= esc_dec_pkg::CH_ZERO) && (in_byte <= esc_dec_pkg::CH_SEVEN);
        is_dec  = (in_byte >= esc_dec_pkg::CH_ZERO) && (in_byte <= esc_dec_pkg::CH_NINE);
        is_uhex = (in_byte >= esc_dec_pkg::CH_UA) && (in_byte <= esc_dec_pkg::CH_UF);
        is_lhex = (in_byte >= esc_dec_pkg::CH_LA) && (in_byte <= esc_dec_pkg::CH_LF_LETTER);
        priority if (is_dec) begin
            hex_val = in_byte[3:0];
        end else if (is_uhex || is_lhex) begin
            hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_val = 4'd0;
        end
        oct_acc = {state.value[4:0], in_byte[2:0]};
        hex_acc = {state.value[3:0], hex_val};
        cnt_inc = state.count + 2'd1;

        unique case (in_byte)
            esc_dec_pkg::CH_LA:        esc_char = 8'd7;
            esc_dec_pkg::CH_LB:        esc_char = 8'd8;
            esc_dec_pkg::CH_LF_LETTER: esc_char = 8'd12;
            esc_dec_pkg::CH_LN:        esc_char = 8'd10;
            esc_dec_pkg::CH_LR:        esc_char = 8'd13;
            esc_dec_pkg::CH_LT:        esc_char = 8'd9;
            esc_dec_pkg::CH_LV:        esc_char = 8'd11;
            esc_dec_pkg::CH_LF:        esc_char = 8'd10;
            default:                   esc_char = in_byte;
        endcase
    end

    always_comb begin
        dec           = '0;
        dec.state     = state;

        unique case (state.mode)
            esc_dec_pkg::MODE_NORMAL: begin
                if (in_byte == esc_dec_pkg::CH_NUL) begin
                    dec.n_results = 2'd1;
                    dec.res0      = '{out_byte: 8'd0, end_of_text: 1'b1, last_of_run: 1'b1};
                    dec.state     = '0;
                end else if (in_byte == esc_dec_pkg::CH_BACKSLASH) begin
                    dec.state.mode = esc_dec_pkg::MODE_ESC;
                end else begin
                    dec.n_results = 2'd1;
                    dec.res0      = '{out_byte: in_byte, end_of_text: 1'b0, last_of_run: 1'b1};
                end
            end
            esc_dec_pkg::MODE_ESC: begin
                dec.state.mode = esc_dec_pkg::MODE_NORMAL;
                if (in_byte == esc_dec_pkg::CH_NUL) begin
                    dec.n_results = 2'd2;
                    dec.res0 = '{out_byte: esc_dec_pkg::CH_BACKSLASH, end_of_text: 1'b0,
                                 last_of_run: 1'b0};
                    dec.res1 = '{out_byte: 8'd0, end_of_text: 1'b1, last_of_run: 1'b1};
                    dec.state = '0;
                end else if (in_byte == esc_dec_pkg::CH_LX) begin
                    dec.state = '{mode: esc_dec_pkg::MODE_HEX, value: 8'd0, count: 2'd0};
                end else if (is_oct) begin
                    dec.state = '{mode: esc_dec_pkg::MODE_OCT, value: {5'd0, in_byte[2:0]},
                                  count: 2'd1};
                end else begin
                    dec.n_results = 2'd1;
                    dec.res0 = '{out_byte: esc_char, end_of_text: 1'b0, last_of_run: 1'b1};
                end
            end
            esc_dec_pkg::MODE_OCT, esc_dec_pkg::MODE_HEX: begin
                if ((state.mode == esc_dec_pkg::MODE_OCT) ? is_oct
                                                          : (is_dec || is_uhex || is_lhex)) begin
                    dec.state.value = (state.mode == esc_dec_pkg::MODE_OCT) ? oct_acc : hex_acc;
                    dec.state.count = cnt_inc;
                    if (cnt_inc >= ((state.mode == esc_dec_pkg::MODE_OCT) ?
                                    esc_dec_pkg::OCT_DIGITS : esc_dec_pkg::HEX_DIGITS)) begin
                        dec.n_results = 2'd1;
                        dec.res0 = '{out_byte: dec.state.value, end_of_text: 1'b0,
                                     last_of_run: 1'b1};
                        dec.state = '0;
                    end
                end else begin
                    // flush the pending value, then treat the byte as plain text
                    dec.res0  = '{out_byte: state.value, end_of_text: 1'b0, last_of_run: 1'b1};
                    dec.state = '0;
                    if (in_byte == esc_dec_pkg::CH_NUL) begin
                        dec.n_results        = 2'd2;
                        dec.res0.last_of_run = 1'b0;
                        dec.res1 = '{out_byte: 8'd0, end_of_text: 1'b1, last_of_run: 1'b1};
                    end else if (in_byte == esc_dec_pkg::CH_BACKSLASH) begin
                        dec.n_results  = 2'd1;
                        dec.state.mode = esc_dec_pkg::MODE_ESC;
                    end else begin
                        dec.n_results        = 2'd2;
                        dec.res0.last_of_run = 1'b0;
                        dec.res1 = '{out_byte: in_byte, end_of_text: 1'b0, last_of_run: 1'b1};
                    end
                end
            end
            default: begin
                dec.state = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
